/* src/srsw_pkg.sv */
// Types and constants shared by the selective-repeat sender window
package srsw_pkg;

   localparam int SEQ_W = 16;
   localparam int CNT_W = 16;
   localparam int CFG_W = 16;
   localparam int WIN_OUT_W = 6;
   localparam int TIME_W = 32;

   localparam logic [1:0] CSR_PACKET_COUNT = 2'd0;
   localparam logic [1:0] CSR_INIT_WINDOW = 2'd1;
   localparam logic [1:0] CSR_INIT_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd3;

   localparam logic [CNT_W-1:0] RST_PACKET_COUNT = 16'd0;
   localparam logic [5:0] RST_INIT_WINDOW = 6'd1;
   localparam logic [5:0] RST_INIT_THRESHOLD = 6'd16;
   localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd2000;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_ACK = 1'b1;

   typedef struct packed {
      logic             func;
      logic [SEQ_W-1:0] ack_seq;
      logic [15:0]      peer_window;
   } req_type;

   typedef struct packed {
      logic                 send_valid;
      logic [SEQ_W-1:0]     send_seq;
      logic                 is_resend;
      logic [WIN_OUT_W-1:0] window_now;
      logic [SEQ_W-1:0]     base_now;
      logic                 finished;
      logic                 last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRD,
      ST_TEV,
      ST_ACK,
      ST_SLIDE,
      ST_GROW,
      ST_FILL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic idx_clr;
      logic idx_inc;
      logic tick_ev;
      logic ack_mark;
      logic slide_step;
      logic grow;
      logic fill_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic ack_ok;
      logic slide_more;
      logic fill_last;
      logic emit_ok;
      logic emit_last;
   } sts_type;

endpackage

/* src/selective_repeat_sender_window.sv */
// Selective-repeat sender window: one item at a time through a slot-serial
// sequencer. A tick scans every slot for a timeout (each slot reads
// its sent time from a single-port memory, then checks it). An acknowledgement
// marks its slot, slides the base and grows the window, or is ignored. Both
// then fill the window slot by slot and transfer the results one at a time,
// holding while the receiver stalls. Configuration writes reload the whole
// transfer state at once; there is no clearing pass.
module selective_repeat_sender_window #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  srsw_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output srsw_pkg::rsp_type          rsp_data,
   input  logic                       csr_write,
   input  logic [1:0]                 csr_index,
   input  logic [srsw_pkg::CFG_W-1:0] csr_wdata
);
   import srsw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   srsw_dpath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* src/srsw_ctrl.sv */
// Sequencer for tick scan, acknowledgement, slide, growth, fill and result transfer
module srsw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   input  srsw_pkg::sts_type sts,
   output srsw_pkg::cmd_type cmd,
   output logic             req_stall
);
   import srsw_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_ACK) ? ST_ACK : ST_TRD;
            end
         end
         ST_TRD: state_in = ST_TEV;
         ST_TEV: state_in = sts.scan_last ? ST_FILL : ST_TRD;
         ST_ACK: state_in = sts.ack_ok ? ST_SLIDE : ST_FILL;
         ST_SLIDE: state_in = sts.slide_more ? ST_SLIDE : ST_GROW;
         ST_GROW: state_in = ST_FILL;
         ST_FILL: state_in = sts.fill_last ? ST_EMIT : ST_FILL;
         ST_EMIT: begin
            if (sts.emit_ok && sts.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            cmd.idx_clr = req_valid;
         end
         ST_TRD: ;
         ST_TEV: begin
            cmd.tick_ev = 1'b1;
            cmd.idx_clr = sts.scan_last;
            cmd.idx_inc = !sts.scan_last;
         end
         ST_ACK: begin
            cmd.ack_mark = sts.ack_ok;
            cmd.idx_clr = !sts.ack_ok;
         end
         ST_SLIDE: cmd.slide_step = sts.slide_more;
         ST_GROW: begin
            cmd.grow = 1'b1;
            cmd.idx_clr = 1'b1;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         ST_EMIT: cmd.emit = sts.emit_ok;
         default: ;
      endcase
   end

endmodule

/* src/srsw_dpath.sv */
// Window state, slot flags, sent-time memory and result register
module srsw_dpath #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  srsw_pkg::req_type            req_data,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output srsw_pkg::rsp_type            rsp_data,
   input  logic                         csr_write,
   input  logic [1:0]                   csr_index,
   input  logic [srsw_pkg::CFG_W-1:0]   csr_wdata,
   input  srsw_pkg::cmd_type            cmd,
   output srsw_pkg::sts_type            sts
);
   import srsw_pkg::*;

   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int WIN_W = $clog2(WINDOW_MAX + 1);
   localparam int TH_W = (WIN_W > 6) ? WIN_W : 6;
   localparam int FLAG_W = 2 * WINDOW_MAX;
   localparam int FIDX_W = $clog2(FLAG_W);

   logic [CNT_W-1:0]  pc_ff, pc_in;
   logic [5:0]        iw_ff, iw_in;
   logic [5:0]        ith_ff, ith_in;
   logic [15:0]       to_ff, to_in;

   logic [SEQ_W-1:0]  base_ff, base_in;
   logic [SLOT_W-1:0] bslot_ff, bslot_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [TH_W-1:0]   thr_ff, thr_in;
   logic              slow_ff, slow_in;
   logic              avoid_ff, avoid_in;
   logic [WINDOW_MAX-1:0] sent_ff, sent_in;
   logic [WINDOW_MAX-1:0] acked_ff, acked_in;
   logic [TIME_W-1:0] tick_ff, tick_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   logic [SEQ_W-1:0]  ack_ff, ack_in;
   logic [15:0]       peer_ff, peer_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [TIME_W-1:0] time_mem [WINDOW_MAX];
   logic [TIME_W-1:0] rd_ff;
   logic              mem_we;

   logic [SLOT_W-1:0] slot_nx, bslot_nx, aslot;
   logic [SEQ_W-1:0]  off;
   logic [SLOT_W:0]   asum;
   logic [WIN_W-1:0]  idx_p1, half;
   logic [CNT_W:0]    fill_seq;
   logic              fill_send, timed_out;
   logic [TIME_W-1:0] age;
   logic [WIN_W:0]    grow_raw;
   logic [15:0]       grow_v;
   logic [WIN_W-1:0]  grow_w;
   logic [FIDX_W-1:0] eidx;
   logic [FLAG_W-1:0] flags_rest;
   logic [SEQ_W-1:0]  eoff;
   logic [TH_W-1:0]   iw_c;

   assign slot_nx = (slot_ff == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_ff + 1'b1;
   assign bslot_nx = (bslot_ff == SLOT_W'(WINDOW_MAX - 1)) ? '0 : bslot_ff + 1'b1;

   assign off = ack_ff - base_ff;
   assign asum = {1'b0, bslot_ff} + (SLOT_W + 1)'(off[SLOT_W-1:0]);
   assign aslot = (asum >= (SLOT_W + 1)'(WINDOW_MAX)) ?
                  SLOT_W'(asum - (SLOT_W + 1)'(WINDOW_MAX)) : SLOT_W'(asum);

   assign idx_p1 = WIN_W'(idx_ff) + WIN_W'(1);
   assign fill_seq = {1'b0, base_ff} + (CNT_W + 1)'(idx_ff);
   assign fill_send = (fill_seq < {1'b0, pc_ff}) && !sent_ff[slot_ff];

   assign age = tick_ff - rd_ff;
   assign timed_out = sent_ff[slot_ff] && !acked_ff[slot_ff] && (age > TIME_W'(to_ff));
   assign half = ((win_ff >> 1) == '0) ? WIN_W'(1) : (win_ff >> 1);

   always_comb begin
      grow_raw = slow_ff ? ({1'b0, win_ff} << 1) : ({1'b0, win_ff} + (WIN_W + 1)'(1));
      grow_v = (16'(grow_raw) > peer_ff) ? peer_ff : 16'(grow_raw);
      if (grow_v == '0) begin
         grow_v = 16'd1;
      end
      if (grow_v > 16'(WINDOW_MAX)) begin
         grow_v = 16'(WINDOW_MAX);
      end
      grow_w = WIN_W'(grow_v);
   end

   always_comb begin
      eidx = '0;
      for (int i = FLAG_W - 1; i >= 0; i--) begin
         if (flags_ff[i]) begin
            eidx = FIDX_W'(i);
         end
      end
   end
   assign flags_rest = flags_ff & (flags_ff - 1'b1);
   assign eoff = (eidx >= FIDX_W'(WINDOW_MAX)) ?
                 SEQ_W'(eidx - FIDX_W'(WINDOW_MAX)) : SEQ_W'(eidx);

   always_comb begin
      pc_in = pc_ff;
      iw_in = iw_ff;
      ith_in = ith_ff;
      to_in = to_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PACKET_COUNT: pc_in = CNT_W'(csr_wdata);
            CSR_INIT_WINDOW: iw_in = csr_wdata[5:0];
            CSR_INIT_THRESHOLD: ith_in = csr_wdata[5:0];
            CSR_TIMEOUT_TICKS: to_in = csr_wdata[15:0];
            default: ;
         endcase
      end
      iw_c = TH_W'(iw_in);
      if (iw_c == '0) begin
         iw_c = TH_W'(1);
      end
      if (iw_c > TH_W'(WINDOW_MAX)) begin
         iw_c = TH_W'(WINDOW_MAX);
      end
   end

   always_comb begin
      base_in = base_ff;
      bslot_in = bslot_ff;
      win_in = win_ff;
      thr_in = thr_ff;
      slow_in = slow_ff;
      avoid_in = avoid_ff;
      sent_in = sent_ff;
      acked_in = acked_ff;
      tick_in = tick_ff;
      idx_in = idx_ff;
      slot_in = slot_ff;
      flags_in = flags_ff;
      ack_in = ack_ff;
      peer_in = peer_ff;
      mem_we = 1'b0;

      if (cmd.load) begin
         ack_in = req_data.ack_seq;
         peer_in = req_data.peer_window;
         flags_in = '0;
         if (req_data.func == FUNC_TICK) begin
            tick_in = tick_ff + 1'b1;
         end
      end
      if (cmd.tick_ev && timed_out) begin
         win_in = half;
         thr_in = TH_W'(half);
         slow_in = 1'b1;
         flags_in[idx_ff] = 1'b1;
         mem_we = 1'b1;
      end
      if (cmd.ack_mark) begin
         acked_in[aslot] = 1'b1;
      end
      if (cmd.slide_step) begin
         sent_in[bslot_ff] = 1'b0;
         acked_in[bslot_ff] = 1'b0;
         base_in = base_ff + 1'b1;
         bslot_in = bslot_nx;
      end
      if (cmd.grow && (slow_ff || avoid_ff)) begin
         win_in = grow_w;
         if (slow_ff && (8'(grow_w) >= 8'(thr_ff))) begin
            slow_in = 1'b0;
            avoid_in = 1'b1;
         end
      end
      if (cmd.fill_step && fill_send) begin
         sent_in[slot_ff] = 1'b1;
         acked_in[slot_ff] = 1'b0;
         flags_in[WINDOW_MAX + int'(idx_ff)] = 1'b1;
         mem_we = 1'b1;
      end
      if (cmd.emit) begin
         flags_in = flags_rest;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
         slot_in = bslot_in;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
         slot_in = slot_nx;
      end

      if (csr_write) begin
         base_in = '0;
         bslot_in = '0;
         win_in = WIN_W'(iw_c);
         thr_in = TH_W'(ith_in);
         slow_in = 1'b1;
         avoid_in = 1'b0;
         sent_in = '0;
         acked_in = '0;
         tick_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.send_valid = (flags_ff != '0);
         rsp_in.send_seq = (flags_ff != '0) ? base_ff + eoff : '0;
         rsp_in.is_resend = (flags_ff != '0) && (eidx < FIDX_W'(WINDOW_MAX));
         rsp_in.window_now = WIN_OUT_W'(win_ff);
         rsp_in.base_now = base_ff;
         rsp_in.finished = (base_ff >= pc_ff);
         rsp_in.last = (flags_rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= RST_PACKET_COUNT;
         iw_ff <= RST_INIT_WINDOW;
         ith_ff <= RST_INIT_THRESHOLD;
         to_ff <= RST_TIMEOUT_TICKS;
         base_ff <= '0;
         bslot_ff <= '0;
         win_ff <= WIN_W'(1);
         thr_ff <= TH_W'(RST_INIT_THRESHOLD);
         slow_ff <= 1'b1;
         avoid_ff <= 1'b0;
         sent_ff <= '0;
         acked_ff <= '0;
         tick_ff <= '0;
         idx_ff <= '0;
         slot_ff <= '0;
         flags_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         iw_ff <= iw_in;
         ith_ff <= ith_in;
         to_ff <= to_in;
         base_ff <= base_in;
         bslot_ff <= bslot_in;
         win_ff <= win_in;
         thr_ff <= thr_in;
         slow_ff <= slow_in;
         avoid_ff <= avoid_in;
         sent_ff <= sent_in;
         acked_ff <= acked_in;
         tick_ff <= tick_in;
         idx_ff <= idx_in;
         slot_ff <= slot_in;
         flags_ff <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_ff <= ack_in;
      peer_ff <= peer_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[slot_ff] <= tick_ff;
      end
      rd_ff <= time_mem[slot_ff];
   end

   assign sts.scan_last = (idx_ff == SLOT_W'(WINDOW_MAX - 1));
   assign sts.ack_ok = (off < SEQ_W'(WINDOW_MAX)) && sent_ff[aslot] && !acked_ff[aslot];
   assign sts.slide_more = (base_ff < pc_ff) && acked_ff[bslot_ff];
   assign sts.fill_last = (idx_p1 >= win_ff) || (idx_ff == SLOT_W'(WINDOW_MAX - 1));
   assign sts.emit_ok = !rsp_valid_ff || !rsp_stall;
   assign sts.emit_last = (flags_rest == '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* bench/tb_selective_repeat_sender_window.sv */
// Self-checking testbench for the selective-repeat sender window with its own window predictor
`timescale 1ns / 1ps

module tb_selective_repeat_sender_window;
   import srsw_pkg::*;

   localparam int WMAX = 32;
   localparam int WATCHDOG_LIMIT = 6000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write;
   logic [1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   selective_repeat_sender_window #(.WINDOW_MAX(WMAX)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // window predictor state
   logic [15:0] cfg_packets;
   logic [5:0] cfg_init_win;
   logic [5:0] cfg_init_thr;
   logic [15:0] cfg_timeout;
   int unsigned win_base;
   int unsigned win_size;
   int unsigned win_thr;
   bit win_slow;
   bit win_avoid;
   bit slot_out[WMAX];
   bit slot_ackd[WMAX];
   logic [31:0] slot_time[WMAX];
   logic [31:0] tick_now;

   req_type pending_reqs[$];
   rsp_type expected_sends[$];
   bit failed;
   bit sender_hold;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned rsp_seen;
   int unsigned stall_hold;
   int unsigned stall_mode_cnt;
   int unsigned stall_mode;
   bit long_stall_done;
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic restart_window();
      win_size = (cfg_init_win == 0) ? 1 : (cfg_init_win > WMAX) ? WMAX : cfg_init_win;
      win_base = 0;
      win_thr = cfg_init_thr;
      win_slow = 1'b1;
      win_avoid = 1'b0;
      tick_now = '0;
      for (int k = 0; k < WMAX; k++) begin
         slot_out[k] = 1'b0;
         slot_ackd[k] = 1'b0;
         slot_time[k] = '0;
      end
   endtask

   function automatic int unsigned clamp_window(int unsigned v, int unsigned peer);
      if (v > peer) v = peer;
      if (v < 1) v = 1;
      if (v > WMAX) v = WMAX;
      return v;
   endfunction

   task automatic predict_sends(req_type r);
      rsp_type step_q[$];
      rsp_type e;
      int unsigned seq;
      int unsigned s;
      int unsigned h;
      logic [31:0] age;
      logic [15:0] off;
      if (r.func == FUNC_TICK) begin
         tick_now = tick_now + 1;
         for (int unsigned i = 0; i < WMAX; i++) begin
            seq = win_base + i;
            s = seq % WMAX;
            age = tick_now - slot_time[s];
            if (slot_out[s] && !slot_ackd[s] && age > {16'd0, cfg_timeout}) begin
               h = win_size / 2;
               if (h < 1) h = 1;
               e = '0;
               e.send_valid = 1'b1;
               e.send_seq = seq[15:0];
               e.is_resend = 1'b1;
               step_q.push_back(e);
               slot_time[s] = tick_now;
               win_thr = h;
               win_size = h;
               win_slow = 1'b1;
            end
         end
      end else begin
         off = r.ack_seq - win_base[15:0];
         if (off < WMAX) begin
            s = (win_base + off) % WMAX;
            if (slot_out[s] && !slot_ackd[s]) begin
               slot_ackd[s] = 1'b1;
               while (win_base < cfg_packets && slot_ackd[win_base % WMAX]) begin
                  slot_out[win_base % WMAX] = 1'b0;
                  slot_ackd[win_base % WMAX] = 1'b0;
                  win_base++;
               end
               if (win_slow) begin
                  win_size = clamp_window(win_size * 2, r.peer_window);
                  if (win_size >= win_thr) begin
                     win_slow = 1'b0;
                     win_avoid = 1'b1;
                  end
               end else if (win_avoid) begin
                  win_size = clamp_window(win_size + 1, r.peer_window);
               end
            end
         end
      end
      for (int unsigned i = 0; i < win_size && i < WMAX; i++) begin
         seq = win_base + i;
         s = seq % WMAX;
         if (seq < cfg_packets && !slot_out[s] && step_q.size() < WMAX) begin
            slot_out[s] = 1'b1;
            slot_ackd[s] = 1'b0;
            slot_time[s] = tick_now;
            e = '0;
            e.send_valid = 1'b1;
            e.send_seq = seq[15:0];
            step_q.push_back(e);
         end
      end
      if (step_q.size() == 0) step_q.push_back('0);
      foreach (step_q[k]) begin
         e = step_q[k];
         e.window_now = win_size[5:0];
         e.base_now = win_base[15:0];
         e.finished = (win_base >= cfg_packets);
         e.last = (k == step_q.size() - 1);
         expected_sends.push_back(e);
      end
   endtask

   // driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) predict_sends(req_data);
         if (req_valid && req_stall) begin
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && !sender_hold) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         failed = 1'b1;
      end
   endfunction

   // monitor and receiver stall pattern
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_seen <= 0;
         stall_hold <= 0;
         stall_mode_cnt <= 0;
         stall_mode <= 0;
         long_stall_done <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_sends.size() == 0) begin
               $error("unexpected transfer: seq %0d", rsp_data.send_seq);
               failed = 1'b1;
            end else begin
               e = expected_sends.pop_front();
               check_field("send_valid", e.send_valid, rsp_data.send_valid);
               check_field("send_seq", e.send_seq, rsp_data.send_seq);
               check_field("is_resend", e.is_resend, rsp_data.is_resend);
               check_field("window_now", e.window_now, rsp_data.window_now);
               check_field("base_now", e.base_now, rsp_data.base_now);
               check_field("finished", e.finished, rsp_data.finished);
               check_field("last", e.last, rsp_data.last);
            end
         end
         if (rsp_seen >= 300 && !long_stall_done) begin
            long_stall_done <= 1'b1;
            stall_hold <= 900;
            rsp_stall <= 1'b1;
         end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_mode_cnt == 0) begin
               stall_mode_cnt <= $urandom_range(20, 120);
               stall_mode <= $urandom_range(0, 2);
            end else begin
               stall_mode_cnt <= stall_mode_cnt - 1;
            end
            rsp_stall <= (stall_mode == 1) ? ($urandom_range(0, 3) == 0) :
                         (stall_mode == 2) ? ($urandom_range(0, 9) < 6) : 1'b0;
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_selective_repeat_sender_window: errors");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_sends.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PACKET_COUNT: cfg_packets = value;
         CSR_INIT_WINDOW: cfg_init_win = value[5:0];
         CSR_INIT_THRESHOLD: cfg_init_thr = value[5:0];
         default: cfg_timeout = value;
      endcase
      restart_window();
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_phase(logic [15:0] pc, logic [15:0] iw, logic [15:0] it,
                            logic [15:0] to);
      wait_drained();
      write_reg(CSR_PACKET_COUNT, pc);
      write_reg(CSR_INIT_WINDOW, iw);
      write_reg(CSR_INIT_THRESHOLD, it);
      write_reg(CSR_TIMEOUT_TICKS, to);
   endtask

   function automatic req_type make_item(bit fn, int unsigned ack, int unsigned peer);
      req_type r;
      r.func = fn;
      r.ack_seq = ack[15:0];
      r.peer_window = peer[15:0];
      return r;
   endfunction

   task automatic feed_random(int unsigned count);
      req_type r;
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         while (pending_reqs.size() >= 2) @(posedge clock);
         pick = $urandom_range(0, 99);
         r.func = (pick < 30) ? FUNC_TICK : FUNC_ACK;
         pick = $urandom_range(0, 99);
         if (pick < 75) r.ack_seq = 16'(win_base + $urandom_range(0, win_size));
         else if (pick < 85) r.ack_seq = 16'(win_base - 1);
         else r.ack_seq = 16'($urandom);
         pick = $urandom_range(0, 99);
         r.peer_window = (pick < 10) ? 16'd0 : (pick < 25) ? 16'hFFFF :
                         (pick < 35) ? 16'($urandom) : 16'($urandom_range(1, 40));
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_PACKET_COUNT;
      csr_wdata = '0;
      failed = 1'b0;
      sender_hold = 1'b0;
      cfg_packets = RST_PACKET_COUNT;
      cfg_init_win = RST_INIT_WINDOW;
      cfg_init_thr = RST_INIT_THRESHOLD;
      cfg_timeout = RST_TIMEOUT_TICKS;
      restart_window();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: nothing to send
      pending_reqs.push_back(make_item(FUNC_TICK, 0, 0));
      pending_reqs.push_back(make_item(FUNC_ACK, 0, 16'hFFFF));

      set_phase(16'd0, 16'd1, 16'd16, 16'd2000);
      pending_reqs.push_back(make_item(FUNC_TICK, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(make_item(FUNC_ACK, 0, 5));

      set_phase(16'd40, 16'd1, 16'd4, 16'd3);
      pending_reqs.push_back(make_item(FUNC_TICK, 0, 0));
      pending_reqs.push_back(make_item(FUNC_ACK, 0, 0));
      pending_reqs.push_back(make_item(FUNC_ACK, 0, 16'hFFFF));
      pending_reqs.push_back(make_item(FUNC_ACK, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(make_item(FUNC_ACK, 2, 16'hFFFF));
      pending_reqs.push_back(make_item(FUNC_ACK, 1, 3));
      pending_reqs.push_back(make_item(FUNC_ACK, 40, 16'hFFFF));
      for (int k = 0; k < 6; k++) pending_reqs.push_back(make_item(FUNC_TICK, 0, 0));
      pending_reqs.push_back(make_item(FUNC_ACK, 3, 1));
      pending_reqs.push_back(make_item(FUNC_ACK, 5, 16'hAAAA));
      pending_reqs.push_back(make_item(FUNC_ACK, 4, 16'h5555));
      feed_random(40);

      set_phase(16'hFFFF, 16'd63, 16'd63, 16'hFFFF);
      feed_random(50);

      set_phase(16'd100, 16'd0, 16'd0, 16'd0);
      feed_random(60);

      set_phase(16'd30, 16'd32, 16'd1, 16'd5);
      feed_random(30);
      sender_hold = 1'b1;
      while (req_valid || expected_sends.size() > 0)
         @(posedge clock);
      sender_hold = 1'b0;
      feed_random(30);

      set_phase(16'd200, 16'd8, 16'd20, 16'd2);
      feed_random(100);

      wait_drained();
      if (!failed)
         $display("tb_selective_repeat_sender_window: clean");
      else
         $display("tb_selective_repeat_sender_window: errors");
      $finish;
   end

endmodule
